### rtl/core/indexed_list_insert_delete_core_defines.svh
// ----------------------------------------------------------------------------
// Indexed list core - assertion macros
// Clocked property checks on clk; ILID_ASSERT is held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_INSERT_DELETE_CORE_DEFINES_SVH
`define INDEXED_LIST_INSERT_DELETE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// check prop on every rising clk edge outside reset
`define ILID_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("indexed list core: property failed");
// check prop on every rising clk edge, reset included
`define ILID_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("indexed list core: property failed");
`else
`define ILID_ASSERT(label, prop)
`define ILID_ASSERT_ALWAYS(label, prop)
`endif

`endif

### rtl/core/ilid_pkg.sv
// ----------------------------------------------------------------------------
// Indexed list core - shared package
// Action and status codes, command and result word types.
// ----------------------------------------------------------------------------
package ilid_pkg;

    typedef enum logic [2:0] {
        ACT_READ     = 3'd0,
        ACT_INS_HEAD = 3'd1,
        ACT_INS_TAIL = 3'd2,
        ACT_INS_POS  = 3'd3,
        ACT_DELETE   = 3'd4
    } ilid_action_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } ilid_status_t;

    localparam int ACTION_W   = 3;
    localparam int POSITION_W = 8;
    localparam int VALUE_W    = 32;
    localparam int TOTAL_W    = 5;

    localparam logic signed [VALUE_W-1:0] NOT_FOUND = -32'sd1;

    // one input word as held in the input register
    typedef struct packed {
        logic [ACTION_W-1:0]          action;
        logic [POSITION_W-1:0]        position;
        logic signed [VALUE_W-1:0]    value;
    } ilid_cmd_t;

    // result of one word, less the entry count
    typedef struct packed {
        logic signed [VALUE_W-1:0]    read_value;
        logic                         found;
        ilid_status_t                 status;
    } ilid_res_t;

endpackage

### rtl/core/indexed_list_insert_delete_core.sv
// ----------------------------------------------------------------------------
// Indexed list insert/delete core
// Ordered list of signed 32-bit values with read, head/tail/positional
// insert and positional delete, held as a shifting register array.
//
//   channel | signals                         | word
//   --------+---------------------------------+-------------------------------
//   in      | in_valid / in_ready             | action, position, value
//   out     | out_valid / out_ready           | read_value, found, status,
//           |                                 | entry_total
//
// One word per cycle sustained while the result side does not stall; a word
// sits in the input register while the array decode and shift run, and its
// result loads into the result register once that register is free or taken.
// Reset clears the entry count and both valid flags; stored values are not
// cleared and an empty list never exposes them.
// A stalled result holds the result register; the input register still takes
// a word and holds it until the result register frees up.
// ----------------------------------------------------------------------------
`include "indexed_list_insert_delete_core_defines.svh"

module indexed_list_insert_delete_core
    import ilid_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [ACTION_W-1:0]       action,
    input  logic [POSITION_W-1:0]     position,
    input  logic signed [VALUE_W-1:0] value,

    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [VALUE_W-1:0] read_value,
    output logic                      found,
    output logic [1:0]                status,
    output logic [TOTAL_W-1:0]        entry_total
);

    localparam int CW = $clog2(CAPACITY + 1);

    // input register
    logic      in_valid_reg;
    ilid_cmd_t cmd_reg;

    // result register
    logic                      out_valid_reg;
    logic signed [VALUE_W-1:0] read_value_reg;
    logic                      found_reg;
    logic [1:0]                status_reg;
    logic [TOTAL_W-1:0]        entry_total_reg;

    logic                      advance;
    ilid_res_t                 res;
    logic [CW-1:0]             count_next;
    logic [CW+TOTAL_W-1:0]     count_wide;
    logic [TOTAL_W-1:0]        entry_total_next;

    // advance the held word whenever the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // entry total is the count masked to its five-bit field
    assign count_wide       = (CW + TOTAL_W)'(count_next);
    assign entry_total_next = count_wide[TOTAL_W-1:0];

    ilid_list_store #(
        .CAPACITY (CAPACITY)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .apply      (advance),
        .cmd        (cmd_reg),
        .res        (res),
        .count_next (count_next)
    );

    // input register: valid flag, then the word itself
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            cmd_reg.action   <= action;
            cmd_reg.position <= position;
            cmd_reg.value    <= value;
        end
    end

    // result register: load on advance, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            read_value_reg  <= res.read_value;
            found_reg       <= res.found;
            status_reg      <= res.status;
            entry_total_reg <= entry_total_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_value  = read_value_reg;
    assign found       = found_reg;
    assign status      = status_reg;
    assign entry_total = entry_total_reg;

    // an empty result register must never block the input side
    `ILID_ASSERT_ALWAYS(a_ready_when_empty, !out_valid_reg |-> in_ready)
    // a hit is always a completed read
    `ILID_ASSERT(a_found_done, out_valid && found |-> status == ST_DONE)
    // anything but a hit reads back the not-found marker
    `ILID_ASSERT(a_miss_marker, out_valid && !found |-> read_value == NOT_FOUND)

endmodule

### rtl/core/ilid_list_store.sv
// ----------------------------------------------------------------------------
// Indexed list core - shifting entry array
// Decodes one command against the stored list, shifts entries on insert or
// delete and gives the result together with the updated entry count.
// ----------------------------------------------------------------------------
module ilid_list_store
    import ilid_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           apply,
    input  ilid_cmd_t                      cmd,
    output ilid_res_t                      res,
    output logic [$clog2(CAPACITY+1)-1:0]  count_next
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int IW   = $clog2(CAPACITY);
    localparam int CMPW = (CW > POSITION_W) ? CW : POSITION_W;

    logic signed [VALUE_W-1:0] store_reg  [CAPACITY];
    logic signed [VALUE_W-1:0] store_next [CAPACITY];
    logic [CW-1:0]             count_reg;

    logic [CMPW-1:0] pos_ext;
    logic [CMPW-1:0] cnt_ext;
    logic [CMPW-1:0] tgt;
    logic            full;
    logic            do_ins;
    logic            do_del;

    assign pos_ext = CMPW'(cmd.position);
    assign cnt_ext = CMPW'(count_reg);
    assign full    = (count_reg == CW'(CAPACITY));

    // decode
    always_comb
    begin
        res.read_value = NOT_FOUND;
        res.found      = 1'b0;
        res.status     = ST_DONE;
        do_ins         = 1'b0;
        do_del         = 1'b0;
        tgt            = pos_ext;
        case (ilid_action_t'(cmd.action))
            ACT_READ:
            begin
                if (pos_ext < cnt_ext)
                begin
                    res.read_value = store_reg[cmd.position[IW-1:0]];
                    res.found      = 1'b1;
                end
                else
                begin
                    res.status = ST_RANGE;
                end
            end
            ACT_INS_HEAD:
            begin
                tgt = '0;
                if (full)
                    res.status = ST_FULL;
                else
                    do_ins = 1'b1;
            end
            ACT_INS_TAIL:
            begin
                tgt = cnt_ext;
                if (full)
                    res.status = ST_FULL;
                else
                    do_ins = 1'b1;
            end
            ACT_INS_POS:
            begin
                if (pos_ext > cnt_ext)
                    res.status = ST_RANGE;
                else if (full)
                    res.status = ST_FULL;
                else
                    do_ins = 1'b1;
            end
            ACT_DELETE:
            begin
                if (pos_ext >= cnt_ext)
                    res.status = ST_RANGE;
                else
                    do_del = 1'b1;
            end
            default:
            begin
                res.status = ST_RANGE;
            end
        endcase
    end

    always_comb
    begin
        if (do_ins)
            count_next = count_reg + CW'(1);
        else if (do_del)
            count_next = count_reg - CW'(1);
        else
            count_next = count_reg;
    end

    // per-entry shift selection
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_entry
        localparam logic [CMPW-1:0] K = CMPW'(g);
        logic signed [VALUE_W-1:0] prev_w;
        logic signed [VALUE_W-1:0] nxt_w;

        if (g == 0)
        begin : g_first
            assign prev_w = store_reg[0];
        end
        else
        begin : g_mid_prev
            assign prev_w = store_reg[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign nxt_w = store_reg[g];
        end
        else
        begin : g_mid_next
            assign nxt_w = store_reg[g+1];
        end

        always_comb
        begin
            store_next[g] = store_reg[g];
            if (do_ins)
            begin
                if (K == tgt)
                    store_next[g] = cmd.value;
                else if (K > tgt)
                    store_next[g] = prev_w;
            end
            else if (do_del)
            begin
                if (K >= tgt)
                    store_next[g] = nxt_w;
            end
        end

        always_ff @(posedge clk)
        begin
            if (apply)
                store_reg[g] <= store_next[g];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (apply)
            count_reg <= count_next;
    end

endmodule
